[rtl/core/second_chance_block_cache_policy_macros.svh]
// Assertion macros for the second-chance cache policy
`ifndef SECOND_CHANCE_BLOCK_CACHE_POLICY_MACROS_SVH
`define SECOND_CHANCE_BLOCK_CACHE_POLICY_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SCBC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%s failed", "label");

// Next-cycle implication checked outside reset.
`define SCBC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%s failed", "label");

`endif

[rtl/core/scbc_pkg.sv]
// -----------------------------------------------------------------------------
// scbc_pkg
// Shared constants, codes and types of the second-chance cache policy.
// -----------------------------------------------------------------------------
`default_nettype none
package scbc_pkg;
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_BLOCK_BITS = 20;
    localparam int CFG_BITS       = 21;
    localparam int OP_BITS        = 2;
    localparam int ST_BITS        = 2;
    localparam int FQ_DEPTH       = 2;

    localparam logic [OP_BITS-1:0] OP_FAULT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_BITS-1:0] OP_FLUSH = 2'd3;

    localparam logic [ST_BITS-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_BITS-1:0] ST_MISSING  = 2'd1;
    localparam logic [ST_BITS-1:0] ST_REJECTED = 2'd2;
    localparam logic [ST_BITS-1:0] ST_RESIDENT = 2'd3;

    localparam logic [CFG_BITS-1:0] BLOCK_COUNT_RESET = 21'd1048576;
    localparam int SUPERBLOCK = 1;
endpackage
`default_nettype wire

[rtl/core/scbc_if.sv]
// -----------------------------------------------------------------------------
// scbc_req_if / scbc_rsp_if
// Valid/ready channels for request and result words.
// -----------------------------------------------------------------------------
`default_nettype none
interface scbc_req_if #(parameter int BLOCK_BITS = 20);
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [BLOCK_BITS-1:0] block_number;
    modport source (output valid, operation, block_number, input ready);
    modport sink   (input valid, operation, block_number, output ready);
endinterface

interface scbc_rsp_if #(parameter int BLOCK_BITS = 20, parameter int CNT_BITS = 5);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic                  evict_valid;
    logic [BLOCK_BITS-1:0] evicted_block;
    logic                  writeback_valid;
    logic [BLOCK_BITS-1:0] writeback_block;
    logic [CNT_BITS-1:0]   resident_count;
    modport source (output valid, status, evict_valid, evicted_block, writeback_valid,
                    writeback_block, resident_count, input ready);
    modport sink   (input valid, status, evict_valid, evicted_block, writeback_valid,
                    writeback_block, resident_count, output ready);
endinterface
`default_nettype wire

[rtl/core/scbc_front.sv]
// -----------------------------------------------------------------------------
// scbc_front
// Accepts request words, range-checks the block and queues them for the back.
// -----------------------------------------------------------------------------
`default_nettype none
module scbc_front
    import scbc_pkg::*;
#(
    parameter int BLOCK_BITS = DEF_BLOCK_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [CFG_BITS-1:0]   i_block_count,
    scbc_req_if.sink                   req,
    output logic                       o_q_valid,
    input  wire logic                  i_q_pop,
    output logic [OP_BITS-1:0]         o_q_op,
    output logic [BLOCK_BITS-1:0]      o_q_blk,
    output logic                       o_q_rej
);
    localparam int W = OP_BITS + BLOCK_BITS + 1;
    localparam int XW = (BLOCK_BITS > CFG_BITS) ? BLOCK_BITS : CFG_BITS;

    logic [W-1:0] r_q [FQ_DEPTH];
    logic         r_wp, r_rp, n_wp, n_rp;
    logic [1:0]   r_cnt, n_cnt;
    logic         w_push, w_rej;
    logic [XW-1:0] w_b, w_c;

    assign w_b = XW'(req.block_number);
    assign w_c = XW'(i_block_count);
    // block_count is 21 bits; wider block numbers compare exactly here
    assign w_rej = (req.block_number == BLOCK_BITS'(0)) ||
                   (req.block_number == BLOCK_BITS'(SUPERBLOCK)) || (w_b >= w_c);

    assign req.ready = (r_cnt != 2'(FQ_DEPTH));
    assign w_push    = req.valid && req.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_op, o_q_blk, o_q_rej} = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
        if (w_push) r_q[r_wp] <= {req.operation, req.block_number, w_rej};
    end
endmodule
`default_nettype wire

[rtl/core/scbc_back.sv]
// -----------------------------------------------------------------------------
// scbc_back
// Sequencer over the entry list: lookup, rotation, eviction, append.
// -----------------------------------------------------------------------------
`default_nettype none
module scbc_back
    import scbc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int BLOCK_BITS = DEF_BLOCK_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_pop,
    input  wire logic [OP_BITS-1:0]    i_q_op,
    input  wire logic [BLOCK_BITS-1:0] i_q_blk,
    input  wire logic                  i_q_rej,
    scbc_rsp_if.source                 rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0, S_FIND = 3'd1, S_ROT = 3'd2,
                           S_COPY = 3'd3, S_FIN = 3'd4, S_OUT = 3'd5;

    logic [BLOCK_BITS-1:0] r_blk [ENTRIES];
    logic [BLOCK_BITS-1:0] r_nb  [ENTRIES];
    logic [ENTRIES-1:0]    r_acc, r_dty, r_nd;
    logic [CW-1:0]         r_cnt, r_i, r_n;
    logic                  r_pass, r_hit;
    logic [IW-1:0]         r_pos;
    logic [2:0]            r_st;
    logic [OP_BITS-1:0]    r_op;
    logic [BLOCK_BITS-1:0] r_b;
    logic [ST_BITS-1:0]    r_status;
    logic                  r_ev, r_wb, r_ov;
    logic [BLOCK_BITS-1:0] r_evb, r_wbb;
    logic [ST_BITS-1:0]    r_ost;
    logic                  r_oev, r_owb;
    logic [BLOCK_BITS-1:0] r_oevb, r_owbb;
    logic [CW-1:0]         r_ocnt;
    logic [IW-1:0]         w_i;

    assign w_i     = r_i[IW-1:0];
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;

    // result word is held in its own register while the next word is worked
    assign rsp.valid           = r_ov;
    assign rsp.status          = r_ost;
    assign rsp.evict_valid     = r_oev;
    assign rsp.evicted_block   = r_oevb;
    assign rsp.writeback_valid = r_owb;
    assign rsp.writeback_block = r_owbb;
    assign rsp.resident_count  = 5'(r_ocnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_acc <= '0; r_dty <= '0; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_op <= i_q_op; r_b <= i_q_blk; r_i <= '0; r_hit <= 1'b0;
                    r_ev <= 1'b0; r_wb <= 1'b0; r_evb <= '0; r_wbb <= '0;
                    r_status <= ST_DONE;
                    if (i_q_rej) begin
                        r_status <= ST_REJECTED; r_st <= S_OUT;
                    end else r_st <= S_FIND;
                end
                S_FIND: begin
                    if (r_i < r_cnt && !r_hit) begin
                        if (r_blk[w_i] == r_b) begin
                            r_hit <= 1'b1; r_pos <= w_i;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i <= '0; r_n <= '0; r_pass <= 1'b0;
                        if (r_op == OP_FAULT) begin
                            if (r_hit) begin
                                r_status <= ST_RESIDENT; r_st <= S_OUT;
                            end else r_st <= S_ROT;
                        end else if (!r_hit) begin
                            r_status <= ST_MISSING; r_st <= S_OUT;
                        end else begin
                            case (r_op)
                                OP_READ:  r_acc[r_pos] <= 1'b1;
                                OP_WRITE: begin
                                    r_acc[r_pos] <= 1'b1; r_dty[r_pos] <= 1'b1;
                                end
                                default: if (r_dty[r_pos]) begin
                                    r_wb <= 1'b1; r_wbb <= r_b; r_dty[r_pos] <= 1'b0;
                                end
                            endcase
                            r_st <= S_OUT;
                        end
                    end
                end
                S_ROT: begin
                    // two stable passes: unaccessed first, then accessed
                    if (r_i < r_cnt) begin
                        if (r_acc[w_i] == r_pass) begin
                            r_nb[r_n[IW-1:0]] <= r_blk[w_i];
                            r_nd[r_n[IW-1:0]] <= r_dty[w_i];
                            r_n <= r_n + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else if (!r_pass) begin
                        r_pass <= 1'b1; r_i <= '0;
                    end else begin
                        r_i <= '0; r_st <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_i < r_cnt) begin
                        r_blk[w_i] <= r_nb[w_i];
                        r_dty[w_i] <= r_nd[w_i];
                        r_acc[w_i] <= 1'b0;
                        r_i <= r_i + 1'b1;
                    end else r_st <= S_FIN;
                end
                S_FIN: begin
                    if (r_cnt == CW'(ENTRIES)) begin
                        r_ev <= 1'b1; r_evb <= r_blk[0];
                        if (r_dty[0]) begin
                            r_wb <= 1'b1; r_wbb <= r_blk[0];
                        end
                        for (int k = 0; k < ENTRIES - 1; k++) begin
                            r_blk[k] <= r_blk[k+1];
                            r_dty[k] <= r_dty[k+1];
                            r_acc[k] <= r_acc[k+1];
                        end
                        r_blk[ENTRIES-1] <= r_b;
                        r_acc[ENTRIES-1] <= 1'b1;
                        r_dty[ENTRIES-1] <= 1'b0;
                    end else begin
                        r_blk[r_cnt[IW-1:0]] <= r_b;
                        r_acc[r_cnt[IW-1:0]] <= 1'b1;
                        r_dty[r_cnt[IW-1:0]] <= 1'b0;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ov) begin
                    r_ov <= 1'b1; r_st <= S_IDLE;
                    r_ost <= r_status; r_oev <= r_ev; r_oevb <= r_evb;
                    r_owb <= r_wb; r_owbb <= r_wbb; r_ocnt <= r_cnt;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/second_chance_block_cache_policy.sv]
// A rejected word goes from the queue straight to the result register. A fault that
// misses runs a lookup walk, two rotation passes and a copy pass, one entry per
// cycle, then append and output. The back sequencer works one word at a time;
// the front queue holds two more words, the result register one finished
// word. Reset clears all marks, the count and the queue.
// -----------------------------------------------------------------------------
// second_chance_block_cache_policy
// Top level: front classifier, word queue and back list sequencer.
// -----------------------------------------------------------------------------
`default_nettype none
`include "second_chance_block_cache_policy_macros.svh"
module second_chance_block_cache_policy
    import scbc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int BLOCK_BITS = DEF_BLOCK_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    scbc_req_if.sink                 req,
    scbc_rsp_if.source               rsp
);
    logic [CFG_BITS-1:0]   r_block_count;
    logic                  w_qv, w_pop, w_rej;
    logic [OP_BITS-1:0]    w_op;
    logic [BLOCK_BITS-1:0] w_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_block_count <= BLOCK_COUNT_RESET;
        else if (i_cfg_we) r_block_count <= i_cfg_data;
    end

    scbc_front #(.BLOCK_BITS(BLOCK_BITS)) u_front (
        .i_clk, .i_rst_n, .i_block_count(r_block_count), .req,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_op(w_op), .o_q_blk(w_blk),
        .o_q_rej(w_rej));

    scbc_back #(.ENTRIES(ENTRIES), .BLOCK_BITS(BLOCK_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_op(w_op),
        .i_q_blk(w_blk), .i_q_rej(w_rej), .rsp);

    `SCBC_ASSERT_IMP(a_pop_has_word, i_clk, i_rst_n, w_pop, w_qv)
    `SCBC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, rsp.valid,
                     rsp.resident_count <= 5'(ENTRIES))
    `SCBC_ASSERT_IMP(a_wb_on_evict, i_clk, i_rst_n, rsp.valid && rsp.evict_valid &&
                     rsp.writeback_valid, rsp.writeback_block == rsp.evicted_block)
    `SCBC_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, rsp.valid && !rsp.ready, rsp.valid)
endmodule
`default_nettype wire

[verif/tb_second_chance_block_cache_policy.sv]
// -----------------------------------------------------------------------------
// tb_second_chance_block_cache_policy
// Drives fault, access and flush words into the second-chance cache policy,
// predicts every result word with a local list model and checks it in order.
// -----------------------------------------------------------------------------
`default_nettype none
module tb_second_chance_block_cache_policy;
    import scbc_pkg::*;

    localparam int NENT = DEF_ENTRIES;
    localparam int BB   = DEF_BLOCK_BITS;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]    status;
        logic          evict_valid;
        logic [BB-1:0] evicted_block;
        logic          writeback_valid;
        logic [BB-1:0] writeback_block;
        logic [4:0]    resident_count;
    } t_result;

    int errors = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        errors++;
    endtask

    class cache_scoreboard;
        logic [CFG_BITS-1:0] blk_limit;
        logic [BB-1:0]       blocks[NENT];
        bit                  acc[NENT];
        bit                  dirty[NENT];
        int                  count;
        t_result             pending[$];

        function new();
            blk_limit = BLOCK_COUNT_RESET;
            count = 0;
            foreach (acc[i]) begin
                acc[i] = 0;
                dirty[i] = 0;
                blocks[i] = '0;
            end
        endfunction

        function void rotate();
            logic [BB-1:0] nb[NENT];
            bit nd[NENT];
            int n;
            n = 0;
            for (int p = 0; p < 2; p++)
                for (int i = 0; i < count; i++)
                    if (acc[i] == (p == 1)) begin
                        nb[n] = blocks[i];
                        nd[n] = dirty[i];
                        n++;
                    end
            for (int i = 0; i < n; i++) begin
                blocks[i] = nb[i];
                dirty[i] = nd[i];
                acc[i] = 0;
            end
        endfunction

        function void note_word(logic [1:0] op, logic [BB-1:0] blk);
            t_result r;
            int pos;
            r = '0;
            pos = -1;
            for (int i = 0; i < count; i++)
                if (pos < 0 && blocks[i] == blk) pos = i;
            if (blk == 0 || blk == SUPERBLOCK || {1'b0, blk} >= blk_limit) begin
                r.status = ST_REJECTED;
            end else if (op == OP_FAULT) begin
                if (pos >= 0) begin
                    r.status = ST_RESIDENT;
                end else begin
                    rotate();
                    if (count >= NENT) begin
                        r.evict_valid = 1;
                        r.evicted_block = blocks[0];
                        if (dirty[0]) begin
                            r.writeback_valid = 1;
                            r.writeback_block = blocks[0];
                        end
                        for (int i = 1; i < NENT; i++) begin
                            blocks[i-1] = blocks[i];
                            acc[i-1] = acc[i];
                            dirty[i-1] = dirty[i];
                        end
                        count = NENT - 1;
                    end
                    blocks[count] = blk;
                    acc[count] = 1;
                    dirty[count] = 0;
                    count++;
                end
            end else if (pos < 0) begin
                r.status = ST_MISSING;
            end else if (op == OP_READ) begin
                acc[pos] = 1;
            end else if (op == OP_WRITE) begin
                acc[pos] = 1;
                dirty[pos] = 1;
            end else if (dirty[pos]) begin
                r.writeback_valid = 1;
                r.writeback_block = blk;
                dirty[pos] = 0;
            end
            r.resident_count = count[4:0];
            pending.push_back(r);
        endfunction

        task check_word(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status) report_mismatch("status", got.status, e.status);
            if (got.evict_valid != e.evict_valid)
                report_mismatch("evict_valid", got.evict_valid, e.evict_valid);
            if (got.evicted_block != e.evicted_block)
                report_mismatch("evicted_block", got.evicted_block, e.evicted_block);
            if (got.writeback_valid != e.writeback_valid)
                report_mismatch("writeback_valid", got.writeback_valid, e.writeback_valid);
            if (got.writeback_block != e.writeback_block)
                report_mismatch("writeback_block", got.writeback_block, e.writeback_block);
            if (got.resident_count != e.resident_count)
                report_mismatch("resident_count", got.resident_count, e.resident_count);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    scbc_req_if #(.BLOCK_BITS(BB)) req();
    scbc_rsp_if #(.BLOCK_BITS(BB), .CNT_BITS(5)) rsp();

    second_chance_block_cache_policy #(.ENTRIES(NENT), .BLOCK_BITS(BB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .req(req.sink), .rsp(rsp.source)
    );

    always #2 i_clk = ~i_clk;

    cache_scoreboard sb = new();
    int send_idle = 0;   // percent
    int recv_stall = 0;  // percent
    bit hold_off = 0;
    int cycles = 0;
    logic [BB-1:0] pool[8];

    initial begin
        req.valid = 0;
        req.operation = OP_FAULT;
        req.block_number = '0;
        rsp.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: sample at the edge, then choose ready for the next one
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_word('{rsp.status, rsp.evict_valid, rsp.evicted_block,
                            rsp.writeback_valid, rsp.writeback_block, rsp.resident_count});
        rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    // valid stays up after a word; an idle draw in the next send or a drain takes it down
    task automatic send_word(input logic [1:0] op, input logic [BB-1:0] blk);
        while ($urandom_range(99) < send_idle) begin
            req.valid <= 0;
            @(posedge i_clk);
        end
        req.valid <= 1;
        req.operation <= op;
        req.block_number <= blk;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        sb.note_word(op, blk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4 * NENT + 10) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_BITS-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.blk_limit = v;
    endtask

    function automatic logic [BB-1:0] pick_block();
        int r;
        r = $urandom_range(99);
        if (r < 80) return BB'(pool[$urandom_range(7)] + $urandom_range(15));
        if (r < 85) return BB'($urandom_range(1));
        return BB'($urandom);
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) send_word(2'($urandom_range(3)), pick_block());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: rejects, full list with eviction and dirty write-back
        send_word(OP_FAULT, 0);
        send_word(OP_READ, SUPERBLOCK);
        send_word(OP_FLUSH, '1);
        send_word(OP_READ, 20'd5);
        for (int i = 0; i < 17; i++) send_word(OP_FAULT, BB'(20'd2 + i));
        send_word(OP_FAULT, 20'd4);
        send_word(OP_WRITE, 20'd4);
        send_word(OP_FLUSH, 20'd4);
        send_word(OP_FLUSH, 20'd4);

        write_limit(21'd2);
        send_word(OP_FAULT, 20'd3);
        write_limit(21'd40);
        send_word(OP_READ, 20'd39);
        send_word(OP_READ, 20'd40);

        for (int i = 0; i < 8; i++) pool[i] = BB'(20'd2 + $urandom_range(40));
        random_phase(170, 0, 0);
        write_limit(BLOCK_COUNT_RESET);
        for (int i = 0; i < 8; i++) pool[i] = BB'($urandom);
        random_phase(170, 51, 0);

        // long receiver hold-off while words keep coming in
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(20, 0, 0);
        join
        drain();

        random_phase(170, 0, 51);
        write_limit(21'd1000);
        for (int i = 0; i < 8; i++) pool[i] = BB'($urandom_range(990));
        random_phase(170, 15, 15);
        write_limit(21'h1FFFFF);
        for (int i = 0; i < 8; i++) pool[i] = BB'($urandom);
        random_phase(170, 0, 0);

        drain();
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
